### rtl/core/rbpsd_pkg.sv
package rbpsd_pkg;

	// Bank size and field widths
	localparam int NUM_RELAYS = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 12;
	localparam logic [CNT_W-1:0] PULSE_LENGTH_RST = 12'h1FF;
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_RELAYS - 1);
	localparam logic [IDX_W:0] NUM_RELAYS_EXT = (IDX_W + 1)'(NUM_RELAYS);

	// Input item actions
	typedef enum logic [1:0] {
		ACT_SET     = 2'd0,
		ACT_ARM     = 2'd1,
		ACT_REFRESH = 2'd2
	} action_t;

	// Stored relay modes; code 3 is never stored
	typedef enum logic [1:0] {
		MODE_ON    = 2'd0,
		MODE_OFF   = 2'd1,
		MODE_PULSE = 2'd2
	} mode_t;

	localparam logic [1:0] MODE_IGNORE = 2'd3;

	// Shift sequencer states
	typedef enum logic {
		SH_IDLE  = 1'b0,
		SH_SHIFT = 1'b1
	} shift_state_t;

	// Status from the shift sequencer to the top level
	typedef struct packed {
		logic busy;
		logic done;
		logic revert;
	} shift_ctl_t;

	// Single write port into the mode store
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		mode_t            mode;
	} mode_wr_t;

endpackage

### rtl/core/relay_bank_pulse_shift_driver.sv
// Set-mode and arm items yield no output item, and ready stays high for them.
// A refresh item yields 32 output items, one bit per cycle from the mode store read
// port, and output stalls pause the shift. A start enters the shift state, then the
// first bit is registered with out_valid; the next input item is taken once the
// state is idle again, from the edge that registers the last bit. Reset (arst_n low)
// sets all relays on, clears the pulse counter and loads pulse_length with 511.
module relay_bank_pulse_shift_driver
	import rbpsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [IDX_W-1:0] relay_index,
	input  logic [1:0]       mode_code,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             serial_bit,
	output logic [IDX_W-1:0] bit_position,
	output logic             latch
);

	logic [CNT_W-1:0] pulse_length_q;
	logic [CNT_W-1:0] counter_q;
	logic accept;
	logic start;
	logic set_ok;
	shift_ctl_t ctl;
	mode_wr_t wr;
	mode_t rd_mode;
	logic [IDX_W-1:0] rd_idx;

	assign in_ready = !ctl.busy;
	assign accept   = in_valid && in_ready;
	assign start    = accept && (action == ACT_REFRESH);
	assign set_ok   = accept && (action == ACT_SET) && (mode_code != MODE_IGNORE)
		&& ({1'b0, relay_index} < NUM_RELAYS_EXT);

	// Select the mode store write: set items when idle, reverts while shifting
	always_comb begin
		wr.en   = set_ok || ctl.revert;
		wr.idx  = ctl.busy ? rd_idx : relay_index;
		wr.mode = ctl.busy ? MODE_ON : mode_t'(mode_code);
	end

	// Hold the configured pulse length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_length_q <= PULSE_LENGTH_RST;
		end else if (cfg_wen) begin
			pulse_length_q <= cfg_wdata;
		end
	end

	// Arm loads the counter; a finished refresh decrements it, saturating at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (accept && (action == ACT_ARM)) begin
			counter_q <= pulse_length_q;
		end else if (ctl.done && (counter_q != '0)) begin
			counter_q <= counter_q - CNT_W'(1);
		end
	end

	rbpsd_mode_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.rd_mode (rd_mode)
	);

	rbpsd_shifter u_shifter (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.pulse_live   (counter_q != '0),
		.rd_mode      (rd_mode),
		.rd_idx       (rd_idx),
		.ctl          (ctl),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.serial_bit   (serial_bit),
		.bit_position (bit_position),
		.latch        (latch)
	);

endmodule

### rtl/core/rbpsd_mode_store.sv
module rbpsd_mode_store
	import rbpsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mode_wr_t         wr,
	input  logic [IDX_W-1:0] rd_idx,
	output mode_t            rd_mode
);

	mode_t mode_q [NUM_RELAYS];

	// Hold one mode per relay; reset puts every relay on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RELAYS; i++) begin
				mode_q[i] <= MODE_ON;
			end
		end else if (wr.en) begin
			mode_q[wr.idx] <= wr.mode;
		end
	end

	// Read the relay under the shift pointer
	assign rd_mode = mode_q[rd_idx];

endmodule

### rtl/core/rbpsd_shifter.sv
module rbpsd_shifter
	import rbpsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             pulse_live,
	input  mode_t            rd_mode,
	output logic [IDX_W-1:0] rd_idx,
	output shift_ctl_t       ctl,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             serial_bit,
	output logic [IDX_W-1:0] bit_position,
	output logic             latch
);

	shift_state_t state_q, state_d;
	logic [IDX_W-1:0] pos_q;
	logic live_q;
	logic out_valid_q;
	logic bit_q;
	logic [IDX_W-1:0] position_q;
	logic latch_q;
	logic advance;
	logic last;
	logic cur_bit;

	assign advance = (state_q == SH_SHIFT) && (!out_valid_q || out_ready);
	assign last    = (pos_q == LAST_POS);

	// Decode the image bit of the current relay
	always_comb begin
		case (rd_mode)
			MODE_OFF:   cur_bit = 1'b1;
			MODE_PULSE: cur_bit = live_q;
			default:    cur_bit = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SH_IDLE: begin
				if (start) state_d = SH_SHIFT;
			end
			SH_SHIFT: begin
				if (advance && last) state_d = SH_IDLE;
			end
			default: state_d = SH_IDLE;
		endcase
	end

	// Status outputs
	always_comb begin
		ctl.busy   = (state_q == SH_SHIFT);
		ctl.done   = advance && last;
		ctl.revert = advance && (rd_mode == MODE_PULSE) && !live_q;
	end

	// Advance the state and the bit pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SH_IDLE;
			pos_q   <= '0;
			live_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				pos_q  <= '0;
				live_q <= pulse_live;
			end else if (advance) begin
				pos_q <= pos_q + IDX_W'(1);
			end
		end
	end

	// Hold the output item until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output payload one bit per cycle while the shift advances
	always_ff @(posedge clk) begin
		if (advance) begin
			bit_q      <= cur_bit;
			position_q <= pos_q;
			latch_q    <= last;
		end
	end

	assign rd_idx       = pos_q;
	assign out_valid    = out_valid_q;
	assign serial_bit   = bit_q;
	assign bit_position = position_q;
	assign latch        = latch_q;

endmodule
